// File: hw/rtl/crcfe_pkg.sv
// ----------------------------------------------------------------------------
// crcfe_pkg: shared types and constants for the CRC-16 short frame encoder
// Holds the per-item command carried from the front to the back, the byte
// sequencer phases and the CRC-16 (poly 0x1021, MSB first) byte update.
// ----------------------------------------------------------------------------
package crcfe_pkg;

   localparam logic [7:0]  FRAME_START = 8'h02;
   localparam logic [7:0]  FRAME_STOP  = 8'h03;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_TOP     = 16'h8000;

   localparam int QUEUE_DEPTH_DEF = 4;

   // One classified request: what the back has to put on the wire for it.
   typedef struct packed {
      logic        open;     // first byte of a frame: start and length first
      logic        close;    // last byte of a frame: CRC and stop after data
      logic [7:0]  data;
      logic [7:0]  len;
      logic [15:0] crc;      // CRC including this byte
   } cmd_type;

   typedef enum logic [2:0] {
      PH_START,
      PH_LEN,
      PH_DATA,
      PH_CRC_HI,
      PH_CRC_LO,
      PH_STOP
   } phase_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/crc16_short_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// crc16_short_frame_encoder_top: CRC-16 short frame encoder
// Wraps payload bytes into 0x02, length, payload, CRC-16 high/low, 0x03.
//
//   channel   direction  handshake          payload
//   --------  ---------  -----------------  -----------------------------------
//   request   in         push / full        req_payload_byte, req_payload_length
//   result    out        empty / pop        rsp_frame_byte, rsp_frame_end
//
// A request is classified and its CRC updated in the cycle it is accepted,
// then queued; one request per cycle is taken while the queue has room.
// While results are popped the back sequencer emits one wire byte per cycle:
// 1 for a middle byte, 3 for a frame's first, 4 for its last, 6 for a one-byte
// frame. Sustained rate is then that sequencer's, one result byte per clock.
// Synchronous reset clears frame state, queue and output register.
// A stalled result side fills the queue, then full holds off requests.
// ----------------------------------------------------------------------------
module crc16_short_frame_encoder_top #(
   parameter int QUEUE_DEPTH = crcfe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_payload_byte,
   input  logic [7:0] req_payload_length,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_frame_end
);

   crcfe_pkg::cmd_type front_cmd;
   crcfe_pkg::cmd_type head_cmd;
   logic cmd_push;
   logic queue_full;
   logic head_valid;
   logic head_pop;

   crcfe_front u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_payload_byte   (req_payload_byte),
      .req_payload_length (req_payload_length),
      .queue_full         (queue_full),
      .cmd_push           (cmd_push),
      .cmd                (front_cmd)
   );

   crcfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_cmd  (front_cmd),
      .q_full  (queue_full),
      .rd_en   (head_pop),
      .q_valid (head_valid),
      .rd_cmd  (head_cmd)
   );

   crcfe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .head_pop       (head_pop),
      .empty          (empty),
      .pop            (pop),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

// File: hw/rtl/crcfe_front.sv
// ----------------------------------------------------------------------------
// crcfe_front: request intake and classification
// Tracks frame position and running CRC, and turns each accepted request
// into one command for the back.
// ----------------------------------------------------------------------------
module crcfe_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [7:0]        req_payload_byte,
   input  logic [7:0]        req_payload_length,
   input  logic              queue_full,
   output logic              cmd_push,
   output crcfe_pkg::cmd_type cmd
);

   logic        in_frame_ff, in_frame_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_base;
   logic [15:0] crc_new;
   logic [7:0]  left_new;
   logic        opening;
   logic        closing;

   assign full     = queue_full;
   assign cmd_push = push && !queue_full;

   always_comb begin
      opening  = !in_frame_ff;
      left_new = opening ? (req_payload_length - 8'd1) : (left_ff - 8'd1);
      closing  = (left_new == 8'd0);
      crc_base = opening ? 16'h0000 : crc_ff;
      crc_new  = crcfe_pkg::crc_feed(crc_base, req_payload_byte);

      cmd.open  = opening;
      cmd.close = closing;
      cmd.data  = req_payload_byte;
      cmd.len   = req_payload_length;
      cmd.crc   = crc_new;

      in_frame_in = in_frame_ff;
      left_in     = left_ff;
      crc_in      = crc_ff;
      if (cmd_push) begin
         in_frame_in = !closing;
         left_in     = left_new;
         crc_in      = closing ? 16'h0000 : crc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         left_ff     <= 8'd0;
         crc_ff      <= 16'h0000;
      end else begin
         in_frame_ff <= in_frame_in;
         left_ff     <= left_in;
         crc_ff      <= crc_in;
      end
   end

endmodule

// File: hw/rtl/crcfe_queue.sv
// ----------------------------------------------------------------------------
// crcfe_queue: command queue between front and back
// Small circular buffer; head entry is visible while not empty.
// ----------------------------------------------------------------------------
module crcfe_queue #(
   parameter int DEPTH = crcfe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  crcfe_pkg::cmd_type wr_cmd,
   output logic               q_full,
   input  logic               rd_en,
   output logic               q_valid,
   output crcfe_pkg::cmd_type rd_cmd
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   crcfe_pkg::cmd_type entries_ff [DEPTH];
   logic [IW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign q_full  = (count_ff == FULL_COUNT);
   assign q_valid = (count_ff != '0);
   assign rd_cmd  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) wr_en |-> !q_full)
      else $error("crcfe_queue: write while full");
   assert property (@(posedge clock) disable iff (reset) rd_en |-> q_valid)
      else $error("crcfe_queue: read while empty");
   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_COUNT)
      else $error("crcfe_queue: count beyond depth");

endmodule

// File: hw/rtl/crcfe_back.sv
// ----------------------------------------------------------------------------
// crcfe_back: frame byte sequencer
// Walks the head command through its wire bytes, one per cycle while the
// result side keeps up, into an output register that the result side drains.
// ----------------------------------------------------------------------------
module crcfe_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  crcfe_pkg::cmd_type head_cmd,
   output logic               head_pop,
   output logic               empty,
   input  logic               pop,
   output logic [7:0]         rsp_frame_byte,
   output logic               rsp_frame_end
);

   crcfe_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic       fresh_ff, fresh_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_end_ff, out_end_in;
   logic       load;
   logic [7:0] emit_byte;
   logic       emit_end;

   assign load = head_valid && (!out_valid_ff || pop);

   // A command not yet begun starts at start byte or straight at its data
   always_comb begin
      if (fresh_ff) begin
         cur_phase = head_cmd.open ? crcfe_pkg::PH_START : crcfe_pkg::PH_DATA;
      end else begin
         cur_phase = phase_ff;
      end
   end

   // Next state
   always_comb begin
      phase_in = phase_ff;
      fresh_in = fresh_ff;
      head_pop = 1'b0;
      if (load) begin
         fresh_in = 1'b0;
         case (cur_phase)
            crcfe_pkg::PH_START: phase_in = crcfe_pkg::PH_LEN;
            crcfe_pkg::PH_LEN:   phase_in = crcfe_pkg::PH_DATA;
            crcfe_pkg::PH_DATA: begin
               if (head_cmd.close) begin
                  phase_in = crcfe_pkg::PH_CRC_HI;
               end else begin
                  head_pop = 1'b1;
                  fresh_in = 1'b1;
               end
            end
            crcfe_pkg::PH_CRC_HI: phase_in = crcfe_pkg::PH_CRC_LO;
            crcfe_pkg::PH_CRC_LO: phase_in = crcfe_pkg::PH_STOP;
            crcfe_pkg::PH_STOP: begin
               head_pop = 1'b1;
               fresh_in = 1'b1;
            end
            default: begin
               head_pop = 1'b1;
               fresh_in = 1'b1;
            end
         endcase
      end
   end

   // Outputs
   always_comb begin
      emit_end = 1'b0;
      case (cur_phase)
         crcfe_pkg::PH_START:  emit_byte = crcfe_pkg::FRAME_START;
         crcfe_pkg::PH_LEN:    emit_byte = head_cmd.len;
         crcfe_pkg::PH_DATA:   emit_byte = head_cmd.data;
         crcfe_pkg::PH_CRC_HI: emit_byte = head_cmd.crc[15:8];
         crcfe_pkg::PH_CRC_LO: emit_byte = head_cmd.crc[7:0];
         crcfe_pkg::PH_STOP: begin
            emit_byte = crcfe_pkg::FRAME_STOP;
            emit_end  = 1'b1;
         end
         default: emit_byte = head_cmd.data;
      endcase

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_end_in   = emit_end;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   assign empty          = !out_valid_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_frame_end  = out_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= crcfe_pkg::PH_START;
         fresh_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
         out_end_ff   <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fresh_ff     <= fresh_in;
         out_valid_ff <= out_valid_in;
         out_end_ff   <= out_end_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
   end

   assert property (@(posedge clock) disable iff (reset) head_pop |-> head_valid)
      else $error("crcfe_back: command retired with none waiting");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_end_ff) |-> (out_byte_ff == crcfe_pkg::FRAME_STOP))
      else $error("crcfe_back: frame end flag on a byte other than stop");
   assert property (@(posedge clock) disable iff (reset)
      (load && cur_phase == crcfe_pkg::PH_STOP) |-> head_cmd.close)
      else $error("crcfe_back: stop byte for a command that does not close");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !pop) |=> out_valid_ff)
      else $error("crcfe_back: result dropped without pop");

endmodule

// File: verif/crc16_short_frame_encoder_top_test.sv
// ----------------------------------------------------------------------------
// crc16_short_frame_encoder_top_test: testbench for the short frame encoder
// Sends payload bytes through the request queue and checks every wire byte
// against an in-bench predictor of the framing and the CRC-16 (0x1021,
// MSB first). Covers one-byte frames, ignored length changes within a frame,
// short random frames under sender and receiver stalls, a drain pause, and
// a longer frame sent back to back.
// ----------------------------------------------------------------------------
module crc16_short_frame_encoder_top_test;

   localparam int STALL_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 16;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [7:0] octet;
      logic       is_end;
   } wire_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [7:0] req_payload_byte = 8'h00;
   logic [7:0] req_payload_length = 8'h00;
   logic       empty;
   logic       pop = 1'b0;
   logic [7:0] rsp_frame_byte;
   logic       rsp_frame_end;

   // predictor state
   logic          frame_open = 1'b0;
   logic [7:0]    bytes_to_go = 8'h00;
   logic [15:0]   running_crc = 16'h0000;
   wire_byte_type wire_bytes_due[$];

   int send_gap_pct = 0;
   int pop_stall_pct = 0;
   int bad_byte_count = 0;
   int quiet_cycles = 0;

   crc16_short_frame_encoder_top dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_payload_byte   (req_payload_byte),
      .req_payload_length (req_payload_length),
      .empty              (empty),
      .pop                (pop),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_frame_end      (rsp_frame_end)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // bit-serial CRC: shift in the data MSB first, fold the poly on feedback
   function automatic logic [15:0] crc_shift_byte(input logic [15:0] crc,
                                                  input logic [7:0] octet);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ octet[i];
         c  = {c[14:0], 1'b0} ^ (fb ? crcfe_pkg::CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   function automatic void frame_accepted_byte(input logic [7:0] data, input logic [7:0] len);
      if (!frame_open) begin
         wire_bytes_due.push_back('{crcfe_pkg::FRAME_START, 1'b0});
         wire_bytes_due.push_back('{len, 1'b0});
         running_crc = 16'h0000;
         bytes_to_go = len - 8'd1;
         frame_open  = 1'b1;
      end else begin
         bytes_to_go = bytes_to_go - 8'd1;
      end
      wire_bytes_due.push_back('{data, 1'b0});
      running_crc = crc_shift_byte(running_crc, data);
      if (bytes_to_go == 8'd0) begin
         wire_bytes_due.push_back('{running_crc[15:8], 1'b0});
         wire_bytes_due.push_back('{running_crc[7:0], 1'b0});
         wire_bytes_due.push_back('{crcfe_pkg::FRAME_STOP, 1'b1});
         frame_open  = 1'b0;
         running_crc = 16'h0000;
      end
   endfunction

   // present one request, hold it until taken
   task automatic send_payload_byte(input logic [7:0] data, input logic [7:0] len);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         push <= 1'b0;
         req_payload_byte <= 8'($urandom);
         req_payload_length <= 8'($urandom);
         @(negedge clock);
      end
      push <= 1'b1;
      req_payload_byte <= data;
      req_payload_length <= len;
      forever begin
         @(posedge clock);
         if (!full) break;
      end
      frame_accepted_byte(data, len);
   endtask

   task automatic send_frame(input logic [7:0] len, input bit random_tail_len);
      int count;
      count = (len == 8'd0) ? 256 : int'(len);
      for (int k = 0; k < count; k++) begin
         send_payload_byte(8'($urandom),
                           (k == 0) ? len : (random_tail_len ? 8'($urandom) : len));
      end
   endtask

   task automatic wait_for_drain();
      while (wire_bytes_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_single_byte_frames();
      send_payload_byte(8'h00, 8'd1);
      send_payload_byte(8'hFF, 8'd1);
      send_payload_byte(8'h80, 8'd1);
      send_payload_byte(8'h01, 8'd1);
      send_payload_byte(8'h55, 8'd1);
   endtask

   task automatic test_length_change_mid_frame();
      // only the first byte's length counts; the rest must be ignored
      send_payload_byte(8'hAA, 8'd4);
      send_payload_byte(8'h00, 8'hFF);
      send_payload_byte(8'hFF, 8'h00);
      send_payload_byte(8'h7F, 8'd1);
      send_payload_byte(8'h31, 8'd3);
      send_payload_byte(8'hC3, 8'd1);
      send_payload_byte(8'h3C, 8'h80);
   endtask

   task automatic test_short_frames();
      send_payload_byte(8'hFF, 8'd2);
      send_payload_byte(8'hFF, 8'd2);
      send_payload_byte(8'h00, 8'd2);
      send_payload_byte(8'h00, 8'd2);
      send_payload_byte(8'h12, 8'd5);
      send_payload_byte(8'h34, 8'd5);
      send_payload_byte(8'h56, 8'd5);
      send_payload_byte(8'h78, 8'd5);
      send_payload_byte(8'h9A, 8'd5);
   endtask

   task automatic test_random_frames(input int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
         send_frame(8'(len), 1'b1);
         sent += len;
      end
   endtask

   task automatic test_drain_pause();
      send_frame(8'd3, 1'b1);
      @(negedge clock);
      push <= 1'b0;
      wait_for_drain();
      send_frame(8'd2, 1'b1);
   endtask

   task automatic test_long_frames();
      send_frame(8'd20, 1'b1);
   endtask

   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      wire_byte_type want;
      if (!reset && pop && !empty) begin
         if (wire_bytes_due.size() == 0) begin
            bad_byte_count++;
            if (bad_byte_count <= REPORT_LIMIT)
               $display("unexpected result: byte %02h end %0b", rsp_frame_byte, rsp_frame_end);
         end else begin
            want = wire_bytes_due.pop_front();
            if (rsp_frame_byte !== want.octet || rsp_frame_end !== want.is_end) begin
               bad_byte_count++;
               if (bad_byte_count <= REPORT_LIMIT)
                  $display("mismatch: expected byte %02h end %0b, got byte %02h end %0b",
                           want.octet, want.is_end, rsp_frame_byte, rsp_frame_end);
            end
         end
      end
   end

   // watchdog: abort when neither side moves for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_gap_pct  = 18;
      pop_stall_pct = 65;
      test_single_byte_frames();
      test_length_change_mid_frame();
      test_short_frames();
      test_random_frames(20);

      send_gap_pct  = 65;
      pop_stall_pct = 18;
      test_drain_pause();
      test_random_frames(20);

      send_gap_pct  = 0;
      pop_stall_pct = 0;
      test_random_frames(10);
      test_long_frames();

      @(negedge clock);
      push <= 1'b0;
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (bad_byte_count == 0 && wire_bytes_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/crcfe_pkg.sv
hw/rtl/crcfe_front.sv
hw/rtl/crcfe_queue.sv
hw/rtl/crcfe_back.sv
hw/rtl/crc16_short_frame_encoder_top.sv
verif/crc16_short_frame_encoder_top_test.sv
